>>> src/csd_pkg.sv
// Shared types and constants for the clutch switch stuck diagnostic.
package csd_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned TimerW    = 10;

  localparam logic [TimerW-1:0] TimerCap = TimerW'(900);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegWinSpdLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWinSpdHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEngSpdMin   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFuelFlowMin = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpdDeact    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSpdNoDecl   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStuckSpdMax = 3'd6;
  localparam logic [CfgIdxW-1:0] RegStuckTimMax = 3'd7;

  // reset values
  localparam logic [7:0]  WinSpdLowRst   = 8'd10;
  localparam logic [7:0]  WinSpdHighRst  = 8'd120;
  localparam logic [7:0]  EngSpdMinRst   = 8'd25;
  localparam logic [15:0] FuelFlowMinRst = 16'd0;
  localparam logic [7:0]  SpdDeactRst    = 8'd200;
  localparam logic [7:0]  SpdNoDeclRst   = 8'd30;
  localparam logic [7:0]  StuckSpdMaxRst = 8'd20;
  localparam logic [15:0] StuckTimMaxRst = 16'd900;

  typedef struct packed {
    logic [7:0]  window_speed_low;
    logic [7:0]  window_speed_high;
    logic [7:0]  engine_speed_min;
    logic [15:0] fuel_flow_min;
    logic [7:0]  speed_deactivate;
    logic [7:0]  speed_no_declutch;
    logic [7:0]  stuck_speed_max;
    logic [15:0] stuck_time_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  vehicle_speed;
    logic [7:0]  engine_speed;
    logic [15:0] fuel_flow;
    logic        key_on;
    logic        engine_running;
    logic        pedal_pressed;
    logic        inhibit;
  } tick_t;

  typedef struct packed {
    logic              coh_start_cond;
    logic              switch_toggled;
    logic              coh_deactivated;
    logic              coh_check_cond;
    logic              stuck_deactivated;
    logic              stuck_counting;
    logic              stuck_held;
    logic              monitor_run;
    logic              stuck_fault;
    logic [TimerW-1:0] stuck_time;
  } result_t;

endpackage

>>> src/csd_cfg.sv
// Configuration register file of the clutch switch stuck diagnostic.
module csd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [csd_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [csd_pkg::CfgDataW-1:0]  data_i,
  output csd_pkg::cfg_t                 cfg_o
);
  import csd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        RegWinSpdLow:   cfg_d.window_speed_low  = data_i[7:0];
        RegWinSpdHigh:  cfg_d.window_speed_high = data_i[7:0];
        RegEngSpdMin:   cfg_d.engine_speed_min  = data_i[7:0];
        RegFuelFlowMin: cfg_d.fuel_flow_min     = data_i;
        RegSpdDeact:    cfg_d.speed_deactivate  = data_i[7:0];
        RegSpdNoDecl:   cfg_d.speed_no_declutch = data_i[7:0];
        RegStuckSpdMax: cfg_d.stuck_speed_max   = data_i[7:0];
        RegStuckTimMax: cfg_d.stuck_time_max    = data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_speed_low  <= WinSpdLowRst;
      cfg_q.window_speed_high <= WinSpdHighRst;
      cfg_q.engine_speed_min  <= EngSpdMinRst;
      cfg_q.fuel_flow_min     <= FuelFlowMinRst;
      cfg_q.speed_deactivate  <= SpdDeactRst;
      cfg_q.speed_no_declutch <= SpdNoDeclRst;
      cfg_q.stuck_speed_max   <= StuckSpdMaxRst;
      cfg_q.stuck_time_max    <= StuckTimMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/csd_core.sv
// Per-tick evaluation: coherence conditions, stuck timer and fault latch.
module csd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  csd_pkg::cfg_t    cfg_i,
  input  csd_pkg::tick_t   tick_i,
  output csd_pkg::result_t res_o
);
  import csd_pkg::*;

  logic              pedal_last_q, window_last_q, expired_last_q;
  logic              counting_q, fault_q;
  logic [TimerW-1:0] timer_q;
  logic              counting_d, fault_d;
  logic [TimerW-1:0] timer_d;

  logic              window, start, toggled, coh_deact, check;
  logic              stuck_deact, held, expired, monitor;
  logic [TimerW-1:0] timer_held;
  logic [TimerW:0]   timer_inc;
  logic [CfgDataW-1:0] timer_lim;

  always_comb begin
    window    = (tick_i.vehicle_speed > cfg_i.window_speed_low) &&
                (tick_i.vehicle_speed < cfg_i.window_speed_high);
    start     = window && (tick_i.engine_speed >= cfg_i.engine_speed_min) &&
                (tick_i.fuel_flow >= cfg_i.fuel_flow_min);
    toggled   = tick_i.pedal_pressed != pedal_last_q;
    coh_deact = tick_i.inhibit || (tick_i.vehicle_speed >= cfg_i.speed_deactivate);
    check     = tick_i.key_on && tick_i.engine_running &&
                (tick_i.vehicle_speed >= cfg_i.speed_no_declutch);

    stuck_deact = toggled || !tick_i.key_on;
    counting_d  = counting_q;
    if (stuck_deact || (window && !window_last_q)) begin
      counting_d = !stuck_deact;
    end

    held       = toggled || (tick_i.vehicle_speed < cfg_i.stuck_speed_max);
    timer_held = held ? '0 : timer_q;

    // expiry is judged before the advance
    expired = {{(CfgDataW-TimerW){1'b0}}, timer_held} >= cfg_i.stuck_time_max;
    monitor = toggled || (expired && !expired_last_q);
    fault_d = monitor ? !toggled : fault_q;

    // saturate at the smaller of the limit and the hard cap
    timer_lim = (cfg_i.stuck_time_max > {{(CfgDataW-TimerW){1'b0}}, TimerCap}) ?
                {{(CfgDataW-TimerW){1'b0}}, TimerCap} : cfg_i.stuck_time_max;
    timer_inc = {1'b0, timer_held} + {{TimerW{1'b0}}, counting_d};
    if (held) begin
      timer_d = '0;
    end else if ({{(CfgDataW-TimerW-1){1'b0}}, timer_inc} > timer_lim) begin
      timer_d = timer_lim[TimerW-1:0];
    end else begin
      timer_d = timer_inc[TimerW-1:0];
    end

    res_o.coh_start_cond    = start;
    res_o.switch_toggled    = toggled;
    res_o.coh_deactivated   = coh_deact;
    res_o.coh_check_cond    = check;
    res_o.stuck_deactivated = stuck_deact;
    res_o.stuck_counting    = counting_d;
    res_o.stuck_held        = held;
    res_o.monitor_run       = monitor;
    res_o.stuck_fault       = fault_d;
    res_o.stuck_time        = timer_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pedal_last_q   <= 1'b0;
      window_last_q  <= 1'b0;
      expired_last_q <= 1'b0;
      counting_q     <= 1'b0;
      fault_q        <= 1'b0;
      timer_q        <= '0;
    end else if (en_i) begin
      pedal_last_q   <= tick_i.pedal_pressed;
      window_last_q  <= window;
      expired_last_q <= expired;
      counting_q     <= counting_d;
      fault_q        <= fault_d;
      timer_q        <= timer_d;
    end
  end

endmodule

>>> src/clutch_switch_stuck_diagnostic_unit.sv
// Clutch pedal switch stuck diagnostic: input register, evaluation, result register.
//
// One request on the input channel is one diagnostic tick; each tick yields
// exactly one result on the output channel, in order.
// Input channel: in_valid_i / in_ready_o with the sampled signals.
// Output channel: out_valid_o / out_ready_i with the derived flags and timer.
// Configuration: cfg_valid_i / cfg_ready_o, cfg_index_i selects the register,
// cfg_data_i carries the value (8-bit registers take the low byte). Always ready.
// Path: the accept edge loads the input register; the evaluated tick then moves into
// the result register when that register is empty or its result is being taken.
// Throughput: one tick per cycle while out_ready_i is high; the per-tick state
// (pedal, window, expiry edges, counting and fault latches, timer) updates on
// the same edge that moves a tick from the input register to the result register.
// Stall: when the receiver holds out_ready_i low the result register holds,
// the input register fills, and in_ready_o drops until the result is taken.
// Reset: registers return to their documented defaults, state and timer clear,
// and both pipeline registers empty.
module clutch_switch_stuck_diagnostic_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [csd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [csd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   vehicle_speed_i,
  input  logic [7:0]                   engine_speed_i,
  input  logic [15:0]                  fuel_flow_i,
  input  logic                         key_on_i,
  input  logic                         engine_running_i,
  input  logic                         pedal_pressed_i,
  input  logic                         inhibit_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         coh_start_cond_o,
  output logic                         switch_toggled_o,
  output logic                         coh_deactivated_o,
  output logic                         coh_check_cond_o,
  output logic                         stuck_deactivated_o,
  output logic                         stuck_counting_o,
  output logic                         stuck_held_o,
  output logic                         monitor_run_o,
  output logic                         stuck_fault_o,
  output logic [csd_pkg::TimerW-1:0]   stuck_time_o
);
  import csd_pkg::*;

  cfg_t    cfg;
  tick_t   tick_q;
  result_t res, res_q;
  logic    in_vld_q, out_vld_q, advance;

  assign cfg_ready_o = 1'b1;

  csd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q.vehicle_speed  <= vehicle_speed_i;
      tick_q.engine_speed   <= engine_speed_i;
      tick_q.fuel_flow      <= fuel_flow_i;
      tick_q.key_on         <= key_on_i;
      tick_q.engine_running <= engine_running_i;
      tick_q.pedal_pressed  <= pedal_pressed_i;
      tick_q.inhibit        <= inhibit_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  csd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cfg_i  (cfg),
    .tick_i (tick_q),
    .res_o  (res)
  );

  assign out_valid_o         = out_vld_q;
  assign coh_start_cond_o    = res_q.coh_start_cond;
  assign switch_toggled_o    = res_q.switch_toggled;
  assign coh_deactivated_o   = res_q.coh_deactivated;
  assign coh_check_cond_o    = res_q.coh_check_cond;
  assign stuck_deactivated_o = res_q.stuck_deactivated;
  assign stuck_counting_o    = res_q.stuck_counting;
  assign stuck_held_o        = res_q.stuck_held;
  assign monitor_run_o       = res_q.monitor_run;
  assign stuck_fault_o       = res_q.stuck_fault;
  assign stuck_time_o        = res_q.stuck_time;

endmodule
